/* hdl/mteu_pkg.sv */
// Shared types, cause codes and helper functions for the machine trap entry unit.
`default_nettype none

package mteu_pkg;

  // Trap classification carried on the result tuser
  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_NO_CAUSE  = 3'd1,
    KIND_BUS_ERROR = 3'd2,
    KIND_MRET      = 3'd3,
    KIND_CAUSE     = 3'd4
  } trap_kind_t;

  localparam int CauseW = 14;

  // Cause flag bit positions
  localparam logic [3:0] BIT_BUS_ERROR      = 4'd0;
  localparam logic [3:0] BIT_ECALL_WRONG    = 4'd1;
  localparam logic [3:0] BIT_MRET           = 4'd2;
  localparam logic [3:0] BIT_STORE_FAULT    = 4'd3;
  localparam logic [3:0] BIT_LOAD_FAULT     = 4'd4;
  localparam logic [3:0] BIT_STORE_MISALIGN = 4'd5;
  localparam logic [3:0] BIT_LOAD_MISALIGN  = 4'd6;
  localparam logic [3:0] BIT_ECALL_M        = 4'd7;
  localparam logic [3:0] BIT_ECALL_S        = 4'd8;
  localparam logic [3:0] BIT_ECALL_U        = 4'd9;
  localparam logic [3:0] BIT_EBREAK         = 4'd10;
  localparam logic [3:0] BIT_INSTR_MISALIGN = 4'd11;
  localparam logic [3:0] BIT_ILLEGAL        = 4'd12;
  localparam logic [3:0] BIT_INSTR_FAULT    = 4'd13;

  // Privilege modes
  localparam logic [1:0] MODE_USER    = 2'd0;
  localparam logic [1:0] MODE_MACHINE = 2'd3;

  // Input item, first field in the highest bits (tuser carries exception_flag)
  typedef struct packed {
    logic [31:0]       mepc_value;
    logic [31:0]       mstatus_value;
    logic [31:0]       branch_target;
    logic [31:0]       instr_pc;
    logic [31:0]       exec_result;
    logic [11:0]       csr_address;
    logic              csr_write_request;
    logic [CauseW-1:0] cause_flags;
  } in_item_t;

  // Result item, first field in the highest bits (tuser carries trap_kind)
  typedef struct packed {
    logic [1:0]  privilege_mode;
    logic [31:0] return_address;
    logic [31:0] trap_value;
    logic [4:0]  cause_code;
    logic [31:0] mepc_new;
    logic [31:0] mstatus_trap;
    logic [31:0] csr_write_data;
    logic [11:0] csr_write_address;
    logic        csr_write;
  } out_item_t;

  localparam int InW     = $bits(in_item_t);
  localparam int InBytes = (InW + 7) / 8;
  localparam int OutW     = $bits(out_item_t);
  localparam int OutBytes = (OutW + 7) / 8;

  // mcause code for a winning cause bit
  function automatic logic [4:0] cause_code_of(input logic [3:0] idx);
    logic [4:0] code;
    code = 5'd0;
    unique case (idx)
      BIT_ECALL_WRONG:    code = 5'd24;
      BIT_STORE_FAULT:    code = 5'd7;
      BIT_LOAD_FAULT:     code = 5'd5;
      BIT_STORE_MISALIGN: code = 5'd6;
      BIT_LOAD_MISALIGN:  code = 5'd4;
      BIT_ECALL_M:        code = 5'd11;
      BIT_ECALL_S:        code = 5'd9;
      BIT_ECALL_U:        code = 5'd8;
      BIT_EBREAK:         code = 5'd3;
      BIT_ILLEGAL:        code = 5'd2;
      BIT_INSTR_FAULT:    code = 5'd1;
      default:            code = 5'd0;
    endcase
    return code;
  endfunction

  // New mstatus: bit31 save flag, bits 12:11 previous mode, bit7 old bit3, bit3 mret
  function automatic logic [31:0] build_mstatus(input logic [31:0] old,
                                                input logic [1:0]  mode,
                                                input logic        save,
                                                input logic        mret);
    logic [31:0] m;
    m       = old;
    m[31]   = save;
    m[12:11] = mode;
    m[7]    = old[3];
    m[3]    = mret;
    return m;
  endfunction

endpackage

`default_nettype wire

/* hdl/mteu_trap_logic.sv */
// Combinational trap decode: priority of cause bits, mstatus build, mode update.
`default_nettype none

module mteu_trap_logic
  import mteu_pkg::*;
(
  input  wire logic       exception_flag,
  input  wire in_item_t   item,
  input  wire logic [1:0] mode,
  output out_item_t       result,
  output trap_kind_t      trap_kind,
  output logic [1:0]      mode_next
);

  logic       trap;
  logic       found;
  logic [3:0] idx;
  logic       save;

  // Lowest set cause bit wins
  always_comb begin
    found = 1'b0;
    idx   = 4'd0;
    for (int i = CauseW - 1; i >= 0; i--) begin
      if (item.cause_flags[i]) begin
        found = 1'b1;
        idx   = 4'(i);
      end
    end
  end

  assign trap = exception_flag | item.cause_flags[BIT_BUS_ERROR];
  assign save = (idx >= BIT_ECALL_M) && (idx <= BIT_EBREAK);

  // Result fields and next privilege mode
  always_comb begin
    result                = '0;
    trap_kind             = KIND_NONE;
    mode_next             = mode;
    result.privilege_mode = mode;
    if (!trap) begin
      if (item.csr_write_request) begin
        result.csr_write         = 1'b1;
        result.csr_write_address = item.csr_address;
        result.csr_write_data    = item.exec_result;
      end
    end else if (!found) begin
      trap_kind = KIND_NO_CAUSE;
    end else if (idx == BIT_BUS_ERROR) begin
      trap_kind           = KIND_BUS_ERROR;
      result.mstatus_trap = build_mstatus(item.mstatus_value, mode, 1'b0, 1'b0);
    end else if (idx == BIT_MRET) begin
      trap_kind             = KIND_MRET;
      result.mstatus_trap   = build_mstatus(item.mstatus_value, mode, 1'b0, 1'b1);
      result.mepc_new       = item.instr_pc;
      result.return_address = item.mepc_value;
      mode_next             = MODE_USER;
    end else begin
      trap_kind           = KIND_CAUSE;
      result.mstatus_trap = build_mstatus(item.mstatus_value, mode, save, 1'b0);
      result.mepc_new     = item.instr_pc;
      result.cause_code   = cause_code_of(idx);
      case (idx) inside
        [BIT_STORE_FAULT:BIT_LOAD_MISALIGN]: result.trap_value = item.exec_result;
        BIT_EBREAK:                          result.trap_value = item.instr_pc;
        BIT_INSTR_MISALIGN:                  result.trap_value = item.branch_target;
        default:                             result.trap_value = 32'd0;
      endcase
      mode_next = MODE_MACHINE;
    end
    result.privilege_mode = mode_next;
  end

endmodule

`default_nettype wire

/* hdl/mteu_out_reg.sv */
// Result register with valid flag driving the master stream side.
`default_nettype none

module mteu_out_reg
  import mteu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire out_item_t             result,
  input  wire trap_kind_t            kind,
  output logic                       free,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OutBytes*8-1:0]      m_tdata,
  output logic [2:0]                 m_tuser
);

  out_item_t  item;
  trap_kind_t item_kind;

  // Slot is free when empty or being drained this cycle
  assign free = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      item      <= result;
      item_kind <= kind;
    end
  end

  assign m_tdata = {{(OutBytes*8-OutW){1'b0}}, item};
  assign m_tuser = item_kind;

endmodule

`default_nettype wire

/* hdl/machine_trap_entry_unit.sv */
// Top level: input register, trap decode, result register and privilege mode state.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while m_tready=1; result register frees as it drains.
// Privilege mode is updated as each item moves from the input to the result register.
// Reset (rst, synchronous): both registers empty, privilege mode set to machine (3).
`default_nettype none

module machine_trap_entry_unit
  import mteu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // cause_flags, csr_write_request, csr_address, exec_result, instr_pc,
  // branch_target, mstatus_value, mepc_value (lowest bit up), zero padded
  input  wire logic [InBytes*8-1:0]  s_tdata,
  // exception_flag
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // csr_write, csr_write_address, csr_write_data, mstatus_trap, mepc_new,
  // cause_code, trap_value, return_address, privilege_mode (lowest bit up), zero padded
  output logic [OutBytes*8-1:0]      m_tdata,
  // trap_kind
  output logic [2:0]                 m_tuser
);

  logic       in_valid;
  in_item_t   in_item;
  logic       in_exc;
  logic [1:0] mode;
  logic [1:0] mode_next;
  logic       out_free;
  logic       advance;
  out_item_t  result;
  trap_kind_t kind;

  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[InW-1:0];
      in_exc  <= s_tuser;
    end
  end

  // Privilege mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MACHINE;
    end else if (advance) begin
      mode <= mode_next;
    end
  end

  mteu_trap_logic u_logic (
    .exception_flag (in_exc),
    .item           (in_item),
    .mode           (mode),
    .result         (result),
    .trap_kind      (kind),
    .mode_next      (mode_next)
  );

  mteu_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .kind     (kind),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

/* hdl/mteu_checker.sv */
// Port-level checks for the machine trap entry unit, bound to the top level.
`default_nettype none

module mteu_checker
  import mteu_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OutBytes*8-1:0] m_tdata,
  input wire logic [2:0]            m_tuser
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A taken trap never forwards a CSR write
  a_no_csr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_NONE |-> m_tdata[0] == 1'b0)
    else $error("CSR write forwarded on a trap");

  // No trap or no known cause leaves all trap fields at zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_NO_CAUSE)
    |-> m_tdata[177:45] == '0)
    else $error("trap fields set without a trap");

  // Mret drops to user mode, a cause trap enters machine mode
  a_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_MRET || m_tuser == KIND_CAUSE)
    |-> m_tdata[179:178] == ((m_tuser == KIND_MRET) ? MODE_USER : MODE_MACHINE))
    else $error("privilege mode wrong after trap");

endmodule

bind machine_trap_entry_unit mteu_checker u_mteu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
